// ----- hw/rtl/amlnsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AML NameString parser package
// Shared types, byte codes and character checks for the name string parser.
// ----------------------------------------------------------------------------
package amlnsp_pkg;

    localparam logic [7:0] BYTE_NULL   = 8'h00;
    localparam logic [7:0] BYTE_ROOT   = 8'h5C;
    localparam logic [7:0] BYTE_PARENT = 8'h5E;
    localparam logic [7:0] BYTE_DUAL   = 8'h2E;
    localparam logic [7:0] BYTE_MULTI  = 8'h2F;

    localparam logic [1:0] PREFIX_NONE     = 2'd0;
    localparam logic [1:0] PREFIX_ROOT     = 2'd1;
    localparam logic [1:0] PREFIX_ANCESTOR = 2'd2;

    localparam logic       STATUS_OK  = 1'b0;
    localparam logic       STATUS_BAD = 1'b1;

    localparam int TDATA_W = 64;

    typedef enum logic [4:0] {
        PH_PREFIX  = 5'b00001,
        PH_PARENTS = 5'b00010,
        PH_KIND    = 5'b00100,
        PH_COUNT   = 5'b01000,
        PH_SEG     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [31:0] segment;
        logic [7:0]  segment_index;
        logic [7:0]  segment_count;
        logic [1:0]  prefix_kind;
        logic [7:0]  ancestor_count;
        logic        last;
        logic        status;
    } result_t;

    function automatic logic lead_ok(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c == 8'h5F);
    endfunction

    function automatic logic char_ok(input logic [7:0] c);
        return lead_ok(c) || (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic segment_ok(input logic [31:0] s);
        return lead_ok(s[7:0]) && char_ok(s[15:8]) && char_ok(s[23:16]) &&
               char_ok(s[31:24]);
    endfunction

endpackage

// ----- hw/rtl/amlnsp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AML NameString parser core
// Parser state registers and the per-byte step logic that produces results.
// ----------------------------------------------------------------------------
module amlnsp_core
    import amlnsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg,   phase_next;
    logic [1:0]  prefix_reg,  prefix_next;
    logic [7:0]  parents_reg, parents_next;
    logic [7:0]  total_reg,   total_next;
    logic [7:0]  done_reg,    done_next;
    logic [31:0] shift_reg,   shift_next;
    logic [1:0]  pos_reg,     pos_next;

    logic [31:0] seg_word;
    logic        seg_good;
    logic        seg_last;

    always_comb begin
        seg_word = shift_reg | ({24'd0, data_byte} << {pos_reg, 3'b000});
        seg_good = segment_ok(seg_word);
        seg_last = ({1'b0, done_reg} + 9'd1) >= {1'b0, total_reg};
    end

    always_comb begin
        phase_next   = phase_reg;
        prefix_next  = prefix_reg;
        parents_next = parents_reg;
        total_next   = total_reg;
        done_next    = done_reg;
        shift_next   = shift_reg;
        pos_next     = pos_reg;
        res_valid    = 1'b0;
        res.segment        = seg_word;
        res.segment_index  = done_reg;
        res.segment_count  = total_reg;
        res.prefix_kind    = prefix_reg;
        res.ancestor_count = parents_reg;
        res.last           = 1'b1;
        res.status         = STATUS_OK;

        case (phase_reg)
            PH_PREFIX, PH_PARENTS, PH_KIND: begin
                if (phase_reg == PH_PREFIX && data_byte == BYTE_ROOT) begin
                    prefix_next = PREFIX_ROOT;
                    phase_next  = PH_KIND;
                end else if (phase_reg == PH_PREFIX && data_byte == BYTE_PARENT) begin
                    prefix_next  = PREFIX_ANCESTOR;
                    parents_next = 8'd1;
                    phase_next   = PH_PARENTS;
                end else if (phase_reg == PH_PARENTS && data_byte == BYTE_PARENT) begin
                    if (parents_reg != 8'hFF) begin
                        parents_next = parents_reg + 8'd1;
                    end
                end else if (data_byte == BYTE_NULL) begin
                    res_valid         = 1'b1;
                    res.segment       = '0;
                    res.segment_index = '0;
                    res.segment_count = '0;
                    phase_next   = PH_PREFIX;
                    prefix_next  = PREFIX_NONE;
                    parents_next = '0;
                    total_next   = '0;
                    done_next    = '0;
                    shift_next   = '0;
                    pos_next     = '0;
                end else if (data_byte == BYTE_DUAL) begin
                    total_next = 8'd2;
                    phase_next = PH_SEG;
                end else if (data_byte == BYTE_MULTI) begin
                    phase_next = PH_COUNT;
                end else begin
                    total_next = 8'd1;
                    phase_next = PH_SEG;
                    shift_next = {24'd0, data_byte};
                    pos_next   = 2'd1;
                end
            end
            PH_COUNT: begin
                if (data_byte == BYTE_NULL) begin
                    res_valid         = 1'b1;
                    res.segment       = '0;
                    res.segment_index = '0;
                    res.segment_count = '0;
                    phase_next   = PH_PREFIX;
                    prefix_next  = PREFIX_NONE;
                    parents_next = '0;
                    total_next   = '0;
                    done_next    = '0;
                    shift_next   = '0;
                    pos_next     = '0;
                end else begin
                    total_next = data_byte;
                    phase_next = PH_SEG;
                end
            end
            PH_SEG: begin
                if (pos_reg != 2'd3) begin
                    shift_next = seg_word;
                    pos_next   = pos_reg + 2'd1;
                end else begin
                    res_valid  = 1'b1;
                    res.last   = !seg_good || seg_last;
                    res.status = seg_good ? STATUS_OK : STATUS_BAD;
                    if (!seg_good || seg_last) begin
                        phase_next   = PH_PREFIX;
                        prefix_next  = PREFIX_NONE;
                        parents_next = '0;
                        total_next   = '0;
                        done_next    = '0;
                        shift_next   = '0;
                        pos_next     = '0;
                    end else begin
                        done_next  = done_reg + 8'd1;
                        shift_next = '0;
                        pos_next   = '0;
                    end
                end
            end
            default: begin
                phase_next   = PH_PREFIX;
                prefix_next  = PREFIX_NONE;
                parents_next = '0;
                total_next   = '0;
                done_next    = '0;
                shift_next   = '0;
                pos_next     = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PREFIX;
            prefix_reg  <= PREFIX_NONE;
            parents_reg <= '0;
            total_reg   <= '0;
            done_reg    <= '0;
            shift_reg   <= '0;
            pos_reg     <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            prefix_reg  <= prefix_next;
            parents_reg <= parents_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            shift_reg   <= shift_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// ----- hw/rtl/aml_name_string_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AML NameString parser
// Byte-stream parser for back-to-back AML NameStrings, one request per segment.
// ----------------------------------------------------------------------------
// Takes one AML byte per cycle and emits one request per four-character name
// segment, a single request for a null name, and an error request (tuser set,
// tlast set) when a segment holds illegal characters, after which parsing
// restarts at the next byte. A byte is registered on entry and its result is
// registered on exit, and the sustained rate is one byte per cycle while no
// new result meets a full output register. The input side keeps accepting
// while a result waits, stalling only when a new result meets a full output
// register.
// ----------------------------------------------------------------------------
module aml_name_string_parser
    import amlnsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [31:0] segment, [39:32] segment_index,
                                          // [47:40] segment_count, [49:48] prefix_kind,
                                          // [57:50] ancestor_count, [63:58] zero
    output logic               m_tlast,   // last
    output logic               m_tuser    // status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       out_free;
    logic       advance;
    logic       res_valid;
    result_t    res;

    amlnsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.ancestor_count, out_reg.prefix_kind,
                       out_reg.segment_count, out_reg.segment_index, out_reg.segment};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;

    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_reg.status == STATUS_BAD) |-> out_reg.last)
        else $error("error request without last");

    a_null_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_reg.segment_count == 8'd0)
            |-> out_reg.last && (out_reg.segment == 32'd0))
        else $error("null name request malformed");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_reg.segment_count != 8'd0)
            |-> out_reg.segment_index < out_reg.segment_count)
        else $error("segment index beyond segment count");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid |-> out_free)
        else $error("result produced with output register full");

endmodule
